// ===== rtl/rdc_pkg.sv =====
// Package for the radix digit converter: transaction structs, field widths,
// digit glyph constants and the digit-to-ASCII function. No dependencies.
package rdc_pkg;

    localparam int NUMBER_W = 63;
    localparam int RADIX_W  = 5;
    localparam int CHAR_W   = 7;
    localparam int DIGIT_W  = 4;
    localparam int STEP_W   = $clog2(NUMBER_W);

    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(NUMBER_W - 1);
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_UA   = 7'h41;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic [RADIX_W-1:0]  radix;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
        logic              bad_radix;
    } out_item_t;

    // Divider control from the sequencer
    typedef struct packed {
        logic load;  // take a fresh dividend
        logic cont;  // divide the held quotient again
    } div_ctrl_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] remainder;
        logic               quo_nz;
    } div_stat_t;

    // Map a digit value 0..15 to '0'..'9', 'A'..'F'
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DIGIT_TEN) begin
            ch = CHAR_ZERO + {3'b000, d};
        end else begin
            ch = CHAR_UA + {3'b000, d - DIGIT_TEN};
        end
        return ch;
    endfunction

endpackage

// ===== rtl/rdc_divider.sv =====
// Bit-serial restoring divider: one dividend bit per cycle, small divisor.
// Depends on rdc_pkg.
module rdc_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rdc_pkg::div_ctrl_t            ctrl,
    input  logic [rdc_pkg::NUMBER_W-1:0]  number,
    input  logic [rdc_pkg::RADIX_W-1:0]   radix,
    output rdc_pkg::div_stat_t            stat
);
    import rdc_pkg::*;

    logic [NUMBER_W-1:0] val_reg, val_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                nz_reg, nz_next;
    logic [DIGIT_W:0]    shifted;
    logic                ge;

    // Shift one dividend bit into the partial remainder and trial-subtract
    always_comb begin
        shifted   = {rem_reg, val_reg[NUMBER_W-1]};
        ge        = (shifted >= radix);
        val_next  = val_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        nz_next   = nz_reg;
        if (ctrl.load || ctrl.cont) begin
            if (ctrl.load) begin
                val_next = number;
            end
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            nz_next   = 1'b0;
        end else if (busy_reg) begin
            val_next = {val_reg[NUMBER_W-2:0], ge};
            rem_next = ge ? DIGIT_W'(shifted - radix) : shifted[DIGIT_W-1:0];
            nz_next  = nz_reg | ge;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        val_reg <= val_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        nz_reg  <= nz_next;
    end

    assign stat.done      = done_reg;
    assign stat.remainder = rem_reg;
    assign stat.quo_nz    = nz_reg;

endmodule

// ===== rtl/rdc_digit_store.sv =====
// Digit stack memory: one write port, one registered read port.
// Depends on rdc_pkg.
module rdc_digit_store #(
    parameter int DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [rdc_pkg::DIGIT_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [rdc_pkg::DIGIT_W-1:0]  rd_data
);
    import rdc_pkg::*;

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [DIGIT_W-1:0] rd_data_reg;

    // Write a digit, read the stack top on request
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/radix_digit_converter.sv =====
// Radix digit converter: each digit comes from a bit-serial division and is
// pushed into the digit store; once all digits are stored they are popped
// and emitted most significant first (held while m_ready is low); a bad radix
// gives its single result in the cycle after acceptance. One item at a time.
// Reset (aresetn, synchronous, active low) returns the sequencer to idle and
// drops any pending result; the digit memory needs no clearing.
module radix_digit_converter #(
    parameter int MAX_DIGITS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rdc_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rdc_pkg::out_item_t m_data
);
    import rdc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_DIGITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_WAIT,
        ST_SEND
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RADIX_W-1:0]  radix_reg, radix_next;
    out_item_t           out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    div_ctrl_t           div_ctrl;
    div_stat_t           div_stat;
    logic                s_hs;
    logic                radix_ok;
    logic [CNT_W-1:0]    cnt_inc;
    logic                more;
    logic                wr_en;
    logic                rd_en;
    logic [DIGIT_W-1:0]  rd_data;

    assign s_hs     = s_valid && s_ready;
    assign radix_ok = s_data.radix inside {[RADIX_MIN:RADIX_MAX]};
    assign cnt_inc  = cnt_reg + 1'b1;
    assign more     = div_stat.quo_nz && (cnt_inc < CNT_LIMIT);
    assign wr_en    = (state_reg == ST_DIV) && div_stat.done;
    assign rd_en    = (state_reg == ST_READ);

    assign div_ctrl.load = s_hs && radix_ok;
    assign div_ctrl.cont = wr_en && more;

    rdc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .number  (s_data.number),
        .radix   (radix_reg),
        .stat    (div_stat)
    );

    rdc_digit_store #(
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (div_stat.remainder),
        .rd_en   (rd_en),
        .rd_addr (ADDR_W'(cnt_reg - 1'b1)),
        .rd_data (rd_data)
    );

    // Sequence: divide and push digits, then pop them most significant first, or flag a bad radix
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        radix_next   = radix_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_hs) begin
                    radix_next = s_data.radix;
                    cnt_next   = '0;
                    if (radix_ok) begin
                        state_next = ST_DIV;
                    end else begin
                        out_next.digit_char = '0;
                        out_next.last_digit = 1'b1;
                        out_next.bad_radix  = 1'b1;
                        m_valid_next        = 1'b1;
                        state_next          = ST_SEND;
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    cnt_next = cnt_inc;
                    if (!more) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cnt_next   = cnt_reg - 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                out_next.digit_char = digit_glyph(rd_data);
                out_next.last_digit = (cnt_reg == '0);
                out_next.bad_radix  = 1'b0;
                m_valid_next        = 1'b1;
                state_next          = ST_SEND;
            end
            ST_SEND: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = out_reg.last_digit ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b0;
            end
        endcase
    end

    // Hold state and the registered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cnt_reg   <= cnt_next;
        radix_reg <= radix_next;
        out_reg   <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/rdc_checker.sv =====
// Port-level checks for the radix digit converter, bound to the top level.
// Depends on rdc_pkg and radix_digit_converter.
module rdc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input rdc_pkg::out_item_t m_data
);
    import rdc_pkg::*;

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    // Never take a transaction while a result is pending
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("input taken while result pending");

    // A bad radix result is the sole, final one and carries no character
    a_bad_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_radix |-> m_data.last_digit && (m_data.digit_char == '0))
        else $error("malformed bad radix result");

    // Good digits are '0'..'9' or 'A'..'F'
    a_glyph: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.bad_radix |->
            (m_data.digit_char >= CHAR_ZERO && m_data.digit_char <= 7'h39) ||
            (m_data.digit_char >= CHAR_UA && m_data.digit_char <= 7'h46))
        else $error("digit character out of range");

    // Reopen the input right after the final result, and only then
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> (s_ready == $past(m_data.last_digit)))
        else $error("input ready does not follow end of run");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);

// ===== test/rdc_digit_checker.sv =====
// Checker for the radix digit converter: watches both channels, predicts the
// digit string of each accepted number and compares every result against it.
// Depends on rdc_pkg for the transaction structs and the glyph constants.
module rdc_digit_checker #(
    parameter int MAX_DIGITS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  rdc_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  rdc_pkg::out_item_t m_data,
    output int                 errors,
    output int                 pending,
    output int                 items_seen,
    output int                 digits_seen,
    output int                 bad_seen
);
    import rdc_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int DIGIT_CAP   = (MAX_DIGITS > STORE_DEPTH) ? STORE_DEPTH :
                                 (MAX_DIGITS < 1) ? 1 : MAX_DIGITS;

    out_item_t digit_q[$];
    out_item_t want;
    int        fail_count;
    int        item_count;
    int        digit_count;
    int        bad_count;

    // Expand one number into its digit transactions, most significant first
    function automatic void predict_digits(input in_item_t item);
        longint unsigned value;
        longint unsigned base;
        logic [3:0]      held [STORE_DEPTH];
        int              count;
        out_item_t       res;
        value = 64'(item.number);
        base  = 64'(item.radix);
        count = 0;
        if (item.radix < RADIX_MIN || item.radix > RADIX_MAX) begin
            res.digit_char = '0;
            res.last_digit = 1'b1;
            res.bad_radix  = 1'b1;
            digit_q.push_back(res);
            return;
        end
        do begin
            held[count] = 4'(value % base);
            count++;
            value = value / base;
        end while (value != 0 && count < DIGIT_CAP);
        for (int k = count - 1; k >= 0; k--) begin
            if (held[k] < 4'd10) begin
                res.digit_char = CHAR_ZERO + 7'(held[k]);
            end else begin
                res.digit_char = CHAR_UA + 7'(held[k] - 4'd10);
            end
            res.last_digit = (k == 0);
            res.bad_radix  = 1'b0;
            digit_q.push_back(res);
        end
    endfunction

    // Predict on input transactions, compare on result transactions
    always @(posedge aclk) begin
        if (!aresetn) begin
            digit_q.delete();
            fail_count  = 0;
            item_count  = 0;
            digit_count = 0;
            bad_count   = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_digits(s_data);
                item_count++;
            end
            if (m_valid && m_ready) begin
                digit_count++;
                if (digit_q.size() == 0) begin
                    $display("%0t: result with nothing pending, got %h", $time, m_data);
                    fail_count++;
                end else begin
                    want = digit_q.pop_front();
                    if (want.bad_radix) begin
                        bad_count++;
                    end
                    if (m_data.digit_char !== want.digit_char) begin
                        $display("%0t: digit_char expected %h, got %h",
                                 $time, want.digit_char, m_data.digit_char);
                        fail_count++;
                    end
                    if (m_data.last_digit !== want.last_digit) begin
                        $display("%0t: last_digit expected %b, got %b",
                                 $time, want.last_digit, m_data.last_digit);
                        fail_count++;
                    end
                    if (m_data.bad_radix !== want.bad_radix) begin
                        $display("%0t: bad_radix expected %b, got %b",
                                 $time, want.bad_radix, m_data.bad_radix);
                        fail_count++;
                    end
                end
            end
        end
        errors      <= fail_count;
        pending     <= digit_q.size();
        items_seen  <= item_count;
        digits_seen <= digit_count;
        bad_seen    <= bad_count;
    end

endmodule

// ===== test/testbench.sv =====
// Top of the radix digit converter testbench: clock, reset, stimulus with
// random idling on both channels, watchdog and verdict.
// Depends on rdc_pkg, radix_digit_converter and rdc_digit_checker.
module testbench;
    import rdc_pkg::*;

    localparam int MAX_DIGITS   = 64;
    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_ITEMS = 110;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    int errors;
    int pending;
    int items_seen;
    int digits_seen;
    int bad_seen;
    int idle_cycles;

    radix_digit_converter #(
        .MAX_DIGITS(MAX_DIGITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    rdc_digit_checker #(
        .MAX_DIGITS(MAX_DIGITS)
    ) digit_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .errors      (errors),
        .pending     (pending),
        .items_seen  (items_seen),
        .digits_seen (digits_seen),
        .bad_seen    (bad_seen)
    );

    // Free-running clock, period 10
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hold off, then present one number until the block takes it
    task automatic send_number(input in_item_t item, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every predicted digit has drained
    task automatic drain_digits();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Receiver: stall a random number of cycles before each result, except in alternate runs of 50 results
    initial begin
        int stall;
        int taken;
        m_ready = 1'b0;
        taken   = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = (((taken / 50) % 2) == 1) ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        in_item_t        item;
        logic [63:0]     raw;
        logic [63:0]     mask;
        logic [NUMBER_W-1:0] all_ones;
        int              bits;
        int              pick;
        bit              quiet;
        all_ones = '1;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: every valid radix with all ones, a top digit, or "100"
        for (int r = 2; r <= 16; r++) begin
            item.radix = RADIX_W'(r);
            if (r % 3 == 0) begin
                item.number = all_ones;
            end else if (r % 3 == 1) begin
                item.number = NUMBER_W'(r - 1);
            end else begin
                item.number = NUMBER_W'(r * r);
            end
            send_number(item, $urandom_range(0, 4));
        end

        // Directed: zero, one and exact powers
        item = '{number: '0, radix: 5'd2};
        send_number(item, $urandom_range(0, 4));
        item = '{number: '0, radix: 5'd10};
        send_number(item, $urandom_range(0, 4));
        item = '{number: NUMBER_W'(1), radix: 5'd2};
        send_number(item, $urandom_range(0, 4));
        item = '{number: NUMBER_W'(1) << 60, radix: RADIX_MAX};
        send_number(item, $urandom_range(0, 4));
        item = '{number: 63'd4052555153018976267, radix: 5'd3};
        send_number(item, $urandom_range(0, 4));

        // Directed: radix below and above the legal range
        item = '{number: NUMBER_W'(12345), radix: 5'd0};
        send_number(item, $urandom_range(0, 4));
        item = '{number: '0, radix: 5'd1};
        send_number(item, $urandom_range(0, 4));
        item = '{number: NUMBER_W'(99), radix: 5'd17};
        send_number(item, $urandom_range(0, 4));
        item = '{number: all_ones, radix: 5'd31};
        send_number(item, $urandom_range(0, 4));

        drain_digits();

        // Random: mostly short numbers in legal bases, a few wide ones
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = ((i / 25) % 2) == 1;
            if ($urandom_range(0, 99) < 15) begin
                pick       = $urandom_range(0, 16);
                item.radix = RADIX_W'((pick < 2) ? pick : pick + 15);
            end else begin
                item.radix = RADIX_W'($urandom_range(2, 16));
            end
            if ($urandom_range(0, 9) < 8) begin
                bits = $urandom_range(0, 16);
            end else begin
                bits = $urandom_range(17, NUMBER_W);
            end
            raw = {$urandom, $urandom};
            if ($urandom_range(0, 9) == 0) begin
                raw = '1;
            end
            mask        = (64'd1 << bits) - 64'd1;
            item.number = NUMBER_W'(raw & mask);
            send_number(item, quiet ? 0 : $urandom_range(0, 4));
            if (i == 40 || i == 90) begin
                drain_digits();
            end
        end

        // Let the last digits drain, then a short settle
        drain_digits();
        repeat (16) @(posedge aclk);

        $display("Converted %0d numbers into %0d results, %0d of them bad-radix flags.",
                 items_seen, digits_seen, bad_seen);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results still pending", errors, pending);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
